### hdl/lpht_pkg.sv
// Package for the linear-probing hash table unit.
// Types, codes and constants shared by the top level and the testbench.
// No dependencies.
`default_nettype none

package lpht_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int CNT_W = 9;   // width of the slot count register

  localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};
  localparam logic [CNT_W-1:0] SLOTS_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_RESERVED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             found;
    status_t          status;
  } rsp_t;

endpackage

`default_nettype wire

### hdl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the key and value stores of the hash table unit.
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/linear_probe_hash_table_unit.sv
// Set/get/remove find the home slot in ST_DIV (2 remainder bits a cycle), probe through
//   ST_READ (key RAM read) and ST_CHECK, then reply from ST_DONE; a reserved key goes straight
//   to ST_DONE; clear walks every slot in ST_CLEAR. One item at a time. Sync reset starts a
//   clearing pass (ST_INIT) over every slot of the key store; req_stall stays high during it,
//   config writes are still taken.
// Depends on lpht_pkg and lpht_ram.
`default_nettype none

module linear_probe_hash_table_unit
  import lpht_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(SLOTS);
  localparam int PW = (AW > CNT_W) ? AW : CNT_W;
  localparam logic [CNT_W-1:0] NMAX = (SLOTS >= 511) ? 9'd511 : CNT_W'(SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  state_t state, state_next;

  logic [CNT_W-1:0] slots_in_use;
  logic [CNT_W-1:0] n_act;
  req_t             item;
  logic [KEY_W-1:0] kshift;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] rem_step;
  logic [4:0]       div_cnt;
  logic [AW-1:0]    pos;
  logic [AW-1:0]    pos_inc;
  logic [CNT_W-1:0] visited;
  logic [AW-1:0]    clr_cnt;
  rsp_t             res;

  logic             key_we;
  logic [AW-1:0]    key_waddr;
  logic [KEY_W-1:0] key_wdata;
  logic             val_we;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;

  logic hit, match, last_probe, rsp_free;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // active slot count: zero reads as one, saturates at the store depth
  always_comb begin
    if (slots_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (slots_in_use > NMAX) begin
      n_act = NMAX;
    end else begin
      n_act = slots_in_use;
    end
  end

  // two restoring remainder steps, key MSB first
  always_comb begin
    logic [CNT_W:0] t1, t2;
    t1 = {rem, kshift[KEY_W-1]};
    if (t1 >= {1'b0, n_act}) begin
      t1 = t1 - {1'b0, n_act};
    end
    t2 = {t1[CNT_W-1:0], kshift[KEY_W-2]};
    if (t2 >= {1'b0, n_act}) begin
      t2 = t2 - {1'b0, n_act};
    end
    rem_step = t2[CNT_W-1:0];
  end

  always_comb begin
    logic [PW-1:0] p1;
    p1 = PW'(pos) + PW'(1);
    pos_inc = (p1 == PW'(n_act)) ? '0 : AW'(p1);
  end

  assign match      = (key_rd == item.key);
  assign hit        = match || (key_rd == EMPTY_KEY);
  assign last_probe = ((visited + CNT_W'(1)) == n_act);

  always_comb begin
    state_next = state;
    key_we     = 1'b0;
    key_waddr  = pos;
    key_wdata  = item.key;
    val_we     = 1'b0;
    case (state)
      ST_INIT: begin
        key_we    = 1'b1;
        key_waddr = clr_cnt;
        key_wdata = EMPTY_KEY;
        if (clr_cnt == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req.op == OP_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (req.key == EMPTY_KEY) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt == '1) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit) begin
          state_next = ST_DONE;
          if (item.op == OP_SET) begin
            key_we = 1'b1;
            val_we = 1'b1;
          end else if (item.op == OP_REMOVE && match) begin
            key_we    = 1'b1;
            key_wdata = EMPTY_KEY;
          end
        end else if (last_probe) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_cnt;
        key_wdata = EMPTY_KEY;
        if (clr_cnt == LAST_SLOT) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slots_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && rsp_free) begin
      rsp <= res;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_INIT, ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          res     <= '{read_value: '0, found: 1'b0, status: STS_OK};
        end
        ST_IDLE: begin
          clr_cnt <= '0;
          if (req_valid) begin
            item    <= req;
            kshift  <= req.key;
            rem     <= '0;
            div_cnt <= '0;
            res     <= '{read_value: '0, found: 1'b0, status: STS_RESERVED};
          end
        end
        ST_DIV: begin
          rem     <= rem_step;
          kshift  <= {kshift[KEY_W-3:0], 2'b00};
          div_cnt <= div_cnt + 5'd1;
          pos     <= AW'(rem_step);
          visited <= '0;
        end
        ST_CHECK: begin
          if (hit) begin
            if (item.op == OP_SET) begin
              res <= '{read_value: item.value, found: 1'b0, status: STS_OK};
            end else if (!match) begin
              res <= '{read_value: '0, found: 1'b0, status: STS_NOT_FOUND};
            end else if (item.op == OP_GET) begin
              res <= '{read_value: val_rd, found: 1'b1, status: STS_OK};
            end else begin
              res <= '{read_value: '0, found: 1'b1, status: STS_OK};
            end
          end else if (last_probe) begin
            res <= '{read_value: '0, found: 1'b0,
                     status: (item.op == OP_SET) ? STS_FULL : STS_NOT_FOUND};
          end else begin
            pos     <= pos_inc;
            visited <= visited + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  lpht_ram #(
    .WIDTH(KEY_W),
    .DEPTH(SLOTS)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_waddr),
    .wdata(key_wdata),
    .raddr(pos),
    .rdata(key_rd)
  );

  lpht_ram #(
    .WIDTH(VAL_W),
    .DEPTH(SLOTS)
  ) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(pos),
    .wdata(item.value),
    .raddr(pos),
    .rdata(val_rd)
  );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for linear_probe_hash_table_unit: set/get/remove/clear traffic
// against an in-bench model of the probed key/value table, under random sender/receiver gaps.
// Depends on lpht_pkg and the unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  localparam int SLOTS = 256;

  logic             clk = 1'b0;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  linear_probe_hash_table_unit #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- table model
  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [CNT_W-1:0] slot_cfg;

  rsp_t             pending_rsp [$];
  logic [KEY_W-1:0] key_pool [$];

  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_found;
  int unsigned n_full;
  int unsigned n_reserved;
  int unsigned n_settings;
  int unsigned burst_left;

  function automatic int unsigned live_slots();
    if (slot_cfg == 0) return 1;
    if (slot_cfg > SLOTS) return SLOTS;
    return 32'(slot_cfg);
  endfunction

  // Applies one request to the model table and returns the response it should give.
  function automatic rsp_t table_apply(req_t r);
    rsp_t        o;
    int unsigned n;
    int unsigned pos;
    int unsigned visited;
    bit          hit;
    o.read_value = '0;
    o.found      = 1'b0;
    o.status     = STS_OK;
    if (r.op == OP_CLEAR) begin
      // clear wipes every physical slot, not just the live ones
      foreach (key_mem[i]) key_mem[i] = EMPTY_KEY;
      return o;
    end
    if (r.key == EMPTY_KEY) begin
      o.status = STS_RESERVED;
      return o;
    end
    n   = live_slots();
    pos = 32'(r.key % n);
    hit = 1'b0;
    for (visited = 0; visited < n && !hit; visited++) begin
      if (key_mem[pos] == r.key || key_mem[pos] == EMPTY_KEY) hit = 1'b1;
      else pos = (pos + 1 == n) ? 0 : pos + 1;
    end
    if (!hit) begin
      o.status = (r.op == OP_SET) ? STS_FULL : STS_NOT_FOUND;
    end else if (r.op == OP_SET) begin
      key_mem[pos] = r.key;
      val_mem[pos] = r.value;
      o.read_value = r.value;
    end else if (key_mem[pos] != r.key) begin
      o.status = STS_NOT_FOUND;
    end else if (r.op == OP_GET) begin
      o.read_value = val_mem[pos];
      o.found      = 1'b1;
    end else begin
      // remove leaves a hole, no tombstone
      key_mem[pos] = EMPTY_KEY;
      o.found      = 1'b1;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- response checker
  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        note_error($sformatf("response with nothing outstanding: rv=%h found=%b status=%0d",
                             rsp.read_value, rsp.found, rsp.status));
      end else begin
        want = pending_rsp.pop_front();
        n_checked++;
        // tally what the traffic exercised, from the predicted side
        if (want.found) n_found++;
        if (want.status == STS_FULL) n_full++;
        if (want.status == STS_RESERVED) n_reserved++;
        if (rsp.read_value !== want.read_value || rsp.found !== want.found ||
            rsp.status !== want.status)
          note_error($sformatf("exp rv=%h found=%b status=%0d, got rv=%h found=%b status=%0d",
                               want.read_value, want.found, want.status,
                               rsp.read_value, rsp.found, rsp.status));
      end
    end
  end

  // Receiver backpressure: pick a mode now and then, from never stalling to mostly stalled.
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 2) == 0);
      2: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= ~rsp_stall;
    endcase
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_req(input op_t op, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] value);
    int unsigned gap;
    req_t        r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    r.op    = op;
    r.key   = key;
    r.value = value;
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    // transfer taken at this edge
    pending_rsp.push_back(table_apply(r));
    n_sent++;
    burst_left--;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [CNT_W-1:0] cnt);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slot_cfg = cnt;
    n_settings++;
  endtask

  function automatic logic [VAL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Keys that tend to share home slots under the current count, plus some extremes.
  task automatic build_key_pool();
    int unsigned      n;
    int unsigned      sz;
    logic [KEY_W-1:0] k;
    n  = live_slots();
    sz = $urandom_range(4, 40);
    key_pool.delete();
    repeat (sz) begin
      case ($urandom_range(0, 3))
        0: k = rand64();
        1: begin
          k = rand64();
          k = k - (k % n) + KEY_W'($urandom_range(0, (n > 8) ? 7 : n - 1));
        end
        2: k = KEY_W'($urandom_range(0, 600));
        default: k = EMPTY_KEY - KEY_W'(1) - KEY_W'($urandom_range(0, 600));
      endcase
      key_pool.push_back(k);
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_basic_ops();
    write_slot_count(SLOTS_RESET);
    send_req(OP_SET, '0, '0);
    send_req(OP_SET, EMPTY_KEY - 1, '1);
    send_req(OP_GET, '0, rand64());
    send_req(OP_GET, EMPTY_KEY - 1, rand64());
    send_req(OP_SET, '0, 64'h0123_4567_89ab_cdef);
    send_req(OP_GET, '0, '0);
    send_req(OP_GET, 64'd77, '0);
    send_req(OP_REMOVE, EMPTY_KEY - 1, '0);
    send_req(OP_REMOVE, EMPTY_KEY - 1, '0);
    // reserved empty-marker key on every keyed op
    send_req(OP_SET, EMPTY_KEY, rand64());
    send_req(OP_GET, EMPTY_KEY, '0);
    send_req(OP_REMOVE, EMPTY_KEY, '0);
    send_req(OP_CLEAR, rand64(), rand64());
    send_req(OP_GET, '0, '0);
  endtask

  // Removing the head of a cluster strands the key behind it.
  task automatic test_cluster_break();
    send_req(OP_SET, 64'd3, rand64());
    send_req(OP_SET, 64'd259, rand64());
    send_req(OP_REMOVE, 64'd3, '0);
    send_req(OP_GET, 64'd259, '0);
  endtask

  // Entries beyond a shrunk count stay hidden; clear still wipes them.
  task automatic test_slot_resize();
    send_req(OP_SET, 64'd10, rand64());
    write_slot_count(9'd4);
    send_req(OP_GET, 64'd10, '0);
    write_slot_count(9'd256);
    send_req(OP_GET, 64'd10, '0);
    write_slot_count(9'd4);
    send_req(OP_CLEAR, '0, '0);
    write_slot_count(9'd256);
    send_req(OP_GET, 64'd10, '0);
  endtask

  task automatic test_table_full();
    write_slot_count(9'd2);
    send_req(OP_SET, 64'd1, rand64());
    send_req(OP_SET, 64'd2, rand64());
    send_req(OP_SET, 64'd3, rand64());
    send_req(OP_SET, 64'd1, rand64());
    send_req(OP_GET, 64'd5, '0);
    // zero count behaves as a single slot
    write_slot_count(9'd0);
    send_req(OP_CLEAR, '0, '0);
    send_req(OP_SET, 64'd7, rand64());
    send_req(OP_SET, 64'd8, rand64());
    send_req(OP_GET, 64'd7, '0);
    write_slot_count(9'h1ff);
    send_req(OP_GET, 64'd7, '0);
  endtask

  task automatic test_random_sweep();
    logic [CNT_W-1:0] counts [12];
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    op_t              op;
    counts = '{9'd256, 9'd16, 9'd4, 9'd1, 9'd2, 9'h1ff, 9'd0, 9'd300, 9'd37, 9'd8, 9'd3, 9'd0};
    foreach (counts[p]) begin
      // last entry is a random small count
      write_slot_count((p == 11) ? CNT_W'($urandom_range(1, 64)) : counts[p]);
      build_key_pool();
      if ($urandom_range(0, 1) == 0) send_req(OP_CLEAR, rand64(), rand64());
      repeat (66) begin
        pick = $urandom_range(0, 99);
        if (pick < 42) op = OP_SET;
        else if (pick < 72) op = OP_GET;
        else if (pick < 92) op = OP_REMOVE;
        else if (pick < 94) op = OP_CLEAR;
        else op = op_t'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 88) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (pick < 93) k = EMPTY_KEY;
        else k = rand64();
        send_req(op, k, rand64());
      end
    end
  endtask

  // ---------------------------------------------------------------- main sequence
  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    foreach (key_mem[i]) key_mem[i] = EMPTY_KEY;
    foreach (val_mem[i]) val_mem[i] = '0;
    slot_cfg   = SLOTS_RESET;
    n_sent     = 0;
    n_checked  = 0;
    n_errors   = 0;
    n_found    = 0;
    n_full     = 0;
    n_reserved = 0;
    n_settings = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_cluster_break();
    test_slot_resize();
    test_table_full();
    test_random_sweep();

    drain_results();
    repeat (600) @(posedge clk);
    foreach (pending_rsp[i]) note_error("response never arrived");
    $display("Ran %0d requests, %0d responses checked, %0d slot-count writes, %0d mismatches",
             n_sent, n_checked, n_settings, n_errors);
    if (n_errors == 0) begin
      $display("linear_probe_hash_table_unit test passed");
    end else begin
      $display("linear_probe_hash_table_unit test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout: %0d of %0d responses seen (hits %0d, full %0d, reserved %0d)",
             n_checked, n_sent, n_found, n_full, n_reserved);
    $display("linear_probe_hash_table_unit test failed");
    $finish;
  end

endmodule
